FILE: hdl/pktb_pkg.sv
// Package for the per-key token bucket limiter: field widths, register indexes,
// register reset values and the slot memory word layout.
// No dependencies; used by the top level and the port checker.
`default_nettype none

package pktb_pkg;

    // Field widths
    localparam int KEY_W = 32;
    localparam int TOK_W = 8;
    localparam int OCC_W = 9;
    localparam int CFG_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DATA_W = 16;

    // Input kinds carried on tuser
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WITHDRAW_COST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_AMOUNT = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_MAX_TOKENS = 8'd12;
    localparam logic [CFG_W-1:0] RST_WITHDRAW_COST = 8'd1;
    localparam logic [CFG_W-1:0] RST_REFILL_AMOUNT = 8'd4;

    // Saturation limit of the reported occupancy
    localparam logic [OCC_W-1:0] OCC_SAT = 9'd511;

    // One slot of the table
    typedef struct packed {
        logic             valid;
        logic [TOK_W-1:0] tokens;
        logic [KEY_W-1:0] key;
    } t_slot;

endpackage

`default_nettype wire

FILE: hdl/per_key_token_bucket_limiter.sv
// Per-key token bucket limiter: table of keys and token counts in one slot memory.
// Depends on pktb_pkg.
//
// The scan reads one slot per cycle through the single read port; a check word then
// passes through an update step before its result is loaded, while a tick word loads
// its result straight after the scan. A new word is accepted only once the result of
// the last one is loaded, and a stalled result word holds the next one back.
// Reset: synchronous, active low; afterwards a clearing pass writes every slot
// as free, and no word is accepted until that pass is done.
`default_nettype none

module per_key_token_bucket_limiter #(
    parameter int ENTRIES = 256
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [pktb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [pktb_pkg::CFG_W-1:0]           i_cfg_data,
    // Input stream
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire  [pktb_pkg::KEY_W-1:0]           i_s_axis_tdata,  // [31:0] key
    input  wire                                  i_s_axis_tuser,  // [0] op
    // Result stream
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    output logic [pktb_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata   // [0] allowed,
                                                                  // [1] untracked,
                                                                  // [10:2] occupancy,
                                                                  // [15:11] zero
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [AW:0] LAST_ADDR = (AW + 1)'(ENTRIES - 1);
    localparam logic [AW:0] END_ADDR = (AW + 1)'(ENTRIES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [pktb_pkg::CFG_W-1:0] r_max;
    logic [pktb_pkg::CFG_W-1:0] r_cost;
    logic [pktb_pkg::CFG_W-1:0] r_refill;

    // Slot memory
    pktb_pkg::t_slot r_slot_mem [ENTRIES];
    pktb_pkg::t_slot r_rdata;

    // Scan and item state
    logic [AW:0]                r_addr;
    logic                       r_rd_vld;
    logic [AW-1:0]              r_rd_idx;
    logic                       r_op;
    logic [pktb_pkg::KEY_W-1:0] r_key;
    logic                       r_hit;
    logic [AW-1:0]              r_hit_idx;
    logic [pktb_pkg::TOK_W-1:0] r_hit_tok;
    logic                       r_free;
    logic [AW-1:0]              r_free_idx;
    logic [CW-1:0]              r_occ;
    logic                       r_res_allowed;
    logic                       r_res_untracked;

    // Output register
    logic                              r_out_valid;
    logic [pktb_pkg::OUT_DATA_W-1:0]   r_out_data;

    // Memory access controls
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    pktb_pkg::t_slot        mem_wdata;

    logic [pktb_pkg::TOK_W:0]   tick_sum;
    logic                       tick_free;
    logic                       upd_withdraw;
    logic                       upd_insert;
    logic [pktb_pkg::TOK_W-1:0] init_tok;
    logic [31:0]                occ_ext;
    logic [pktb_pkg::OCC_W-1:0] occ_sat;
    logic                       in_acc;
    logic                       out_free;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Refill of the slot just read, and the decisions of the update step
    always_comb begin
        tick_sum = {1'b0, r_rdata.tokens} + {1'b0, r_refill};
        tick_free = tick_sum >= {1'b0, r_max};
        init_tok = (r_max > r_cost) ? (r_max - r_cost) : '0;
        upd_withdraw = r_hit && (r_hit_tok >= r_cost);
        upd_insert = !r_hit && r_free;
        occ_ext = 32'(r_occ);
        occ_sat = (occ_ext > 32'(pktb_pkg::OCC_SAT)) ? pktb_pkg::OCC_SAT
                                                     : occ_ext[pktb_pkg::OCC_W-1:0];
    end

    // Steer memory read and write ports
    always_comb begin
        mem_re = (r_state == S_SCAN) && (r_addr != END_ADDR);
        mem_raddr = r_addr[AW-1:0];
        mem_we = 1'b0;
        mem_waddr = r_addr[AW-1:0];
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_SCAN: begin
                if (r_rd_vld && (r_op == pktb_pkg::OP_TICK) && r_rdata.valid) begin
                    mem_we = 1'b1;
                    mem_waddr = r_rd_idx;
                    if (!tick_free) begin
                        mem_wdata.valid = 1'b1;
                        mem_wdata.tokens = tick_sum[pktb_pkg::TOK_W-1:0];
                        mem_wdata.key = r_rdata.key;
                    end
                end
            end
            S_UPDATE: begin
                mem_wdata.valid = 1'b1;
                mem_wdata.key = r_key;
                if (upd_withdraw) begin
                    mem_we = 1'b1;
                    mem_waddr = r_hit_idx;
                    mem_wdata.tokens = r_hit_tok - r_cost;
                end else if (upd_insert) begin
                    mem_we = 1'b1;
                    mem_waddr = r_free_idx;
                    mem_wdata.tokens = init_tok;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_slot_mem[mem_raddr];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= pktb_pkg::RST_MAX_TOKENS;
            r_cost <= pktb_pkg::RST_WITHDRAW_COST;
            r_refill <= pktb_pkg::RST_REFILL_AMOUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pktb_pkg::REG_MAX_TOKENS: r_max <= i_cfg_data;
                pktb_pkg::REG_WITHDRAW_COST: r_cost <= i_cfg_data;
                pktb_pkg::REG_REFILL_AMOUNT: r_refill <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: clear, accept, scan, update, hand over the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_rd_vld <= 1'b0;
            r_occ <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result word once taken, unless a new one is loaded now
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST_ADDR) begin
                        r_addr <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op <= i_s_axis_tuser;
                        r_key <= i_s_axis_tdata;
                        r_addr <= '0;
                        r_rd_vld <= 1'b0;
                        r_hit <= 1'b0;
                        r_free <= 1'b0;
                        r_res_allowed <= 1'b0;
                        r_res_untracked <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue the next read
                    r_rd_vld <= mem_re;
                    r_rd_idx <= r_addr[AW-1:0];
                    if (mem_re) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    // Process the slot read in the previous cycle
                    if (r_rd_vld && r_rdata.valid) begin
                        if (r_op == pktb_pkg::OP_TICK) begin
                            if (tick_free) begin
                                r_occ <= r_occ - 1'b1;
                            end
                        end else if (!r_hit && (r_rdata.key == r_key)) begin
                            r_hit <= 1'b1;
                            r_hit_idx <= r_rd_idx;
                            r_hit_tok <= r_rdata.tokens;
                        end
                    end else if (r_rd_vld && !r_free) begin
                        r_free <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                    if (!mem_re && !r_rd_vld) begin
                        r_state <= (r_op == pktb_pkg::OP_TICK) ? S_DONE : S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_res_allowed <= !r_hit || upd_withdraw;
                    r_res_untracked <= !r_hit && !r_free;
                    if (upd_insert) begin
                        r_occ <= r_occ + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data <= {{(pktb_pkg::OUT_DATA_W - pktb_pkg::OCC_W - 2){1'b0}},
                                       occ_sat, r_res_untracked, r_res_allowed};
                        r_state <= S_IDLE;
                    end else if (i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = r_out_data;

endmodule

`default_nettype wire

FILE: hdl/pktb_checker.sv
// Port checker for the per-key token bucket limiter, bound to the top level.
// Depends on pktb_pkg and per_key_token_bucket_limiter.
`default_nettype none

module pktb_checker #(
    parameter int ENTRIES = 256
) (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_cfg_we,
    input wire [pktb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input wire [pktb_pkg::CFG_W-1:0]        i_cfg_data,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire [pktb_pkg::KEY_W-1:0]        i_s_axis_tdata,
    input wire                              i_s_axis_tuser,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [pktb_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    logic [31:0] occ_limit;
    assign occ_limit = (ENTRIES > 511) ? 32'd511 : 32'(ENTRIES);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    // An untracked key is always admitted
    a_untracked_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[0] || !o_m_axis_tdata[1]))
        else $error("untracked result not admitted");

    // Occupancy stays within the table size
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (32'(o_m_axis_tdata[10:2]) <= occ_limit))
        else $error("occupancy above table size");

    // One word at a time: input closes after an accepted word
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second word accepted while busy");

    // Reset empties the result side and closes the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("ports active right after reset");

endmodule

bind per_key_token_bucket_limiter pktb_checker #(.ENTRIES(ENTRIES)) u_pktb_checker (.*);

`default_nettype wire
